// File: hw/rtl/lpr_pkg.sv
// Shared types and constants for the line pixel rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

    localparam int COORD_BITS = 8;
    localparam int COLOR_BITS = 32;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = '1;

    // Action codes of an input item
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    typedef struct packed {
        logic                  action;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last_pixel;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/line_pixel_rasterizer.sv
// Top level of the line pixel rasterizer: controller, datapath and checks.
//
//  channel  | signals                      | payload
//  ---------+------------------------------+---------------------------------
//  input    | s_valid / s_ready / s_data   | action, start_x, start_y, end_x, end_y
//  result   | m_valid / m_ready / m_data   | pixel_x, pixel_y, pixel_color, last_pixel
//  config   | cfg_wr_en / cfg_wr_data      | draw_color
//
// A start item is first loaded, which orders the endpoints, then set up, which computes the
// span and minor step; s_ready is low during setup.
// For a next item, the minor coordinate comes from a running quotient and remainder
// updated by one add and compare per pixel.
// The output register frees s_ready again in the cycle its item is taken.
// Reset is synchronous, active low; draw_color resets to all ones, the block idle.
`timescale 1ns / 1ps
`default_nettype none

module line_pixel_rasterizer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire lpr_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output lpr_pkg::out_item_t                  m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [lpr_pkg::COLOR_BITS-1:0] cfg_wr_data
);

    lpr_pkg::dp_cmd_t  dp_cmd;
    lpr_pkg::dp_stat_t dp_stat;

    lpr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_data.action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    lpr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .dp_cmd      (dp_cmd),
        .dp_stat     (dp_stat),
        .m_data      (m_data)
    );

    // a pixel is only produced into a free or draining output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.step |-> (!m_valid || m_ready))
        else $error("pixel step overwrote a pending result item");

    // after the final pixel the next cycle cannot step again
    assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_cmd.step && dp_stat.last) |=> !dp_cmd.step)
        else $error("pixel step issued after the last pixel");

    // setup does not repeat in the next cycle and blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.setup |=> (!dp_cmd.setup && $past(!s_ready)))
        else $error("setup phase did not complete in one cycle");

endmodule

`default_nettype wire

// File: hw/rtl/lpr_ctrl.sv
// Controller state machine for the line pixel rasterizer.
`timescale 1ns / 1ps
`default_nettype none

module lpr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_action,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lpr_pkg::dp_cmd_t        dp_cmd,
    input  wire lpr_pkg::dp_stat_t  dp_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       accept;

    assign s_ready = (state_reg != S_SETUP) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        dp_cmd.load  = accept && (s_action == lpr_pkg::ACT_START);
        dp_cmd.setup = (state_reg == S_SETUP);
        dp_cmd.step  = accept && (s_action == lpr_pkg::ACT_NEXT) && (state_reg == S_RUN);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (dp_cmd.load) state_next = S_SETUP;
            end
            S_SETUP: begin
                state_next = S_RUN;
            end
            S_RUN: begin
                // a new start abandons the current line
                if (dp_cmd.load) begin
                    state_next = S_SETUP;
                end else if (dp_cmd.step && dp_stat.last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (dp_cmd.step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lpr_datapath.sv
// Datapath: endpoint ordering, incremental minor-axis quotient, output register.
`timescale 1ns / 1ps
`default_nettype none

module lpr_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lpr_pkg::in_item_t                   s_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lpr_pkg::COLOR_BITS-1:0]      cfg_wr_data,
    input  wire lpr_pkg::dp_cmd_t                    dp_cmd,
    output lpr_pkg::dp_stat_t                        dp_stat,
    output lpr_pkg::out_item_t                       m_data
);

    localparam int CB = lpr_pkg::COORD_BITS;

    logic [lpr_pkg::COLOR_BITS-1:0] color_reg;

    logic [CB-1:0] major_now_reg, major_first_reg, major_last_reg;
    logic [CB-1:0] minor_first_reg, minor_last_reg;
    logic          steep_reg;

    logic [CB-1:0]        den_reg;
    logic signed [CB:0]   dn_reg;
    logic [CB-1:0]        q_reg, q_next;
    logic signed [CB+1:0] r_reg, r_next;

    lpr_pkg::out_item_t out_reg;

    // start item decode
    logic [CB-1:0] span_x, span_y;
    logic          steep;
    logic [CB-1:0] m0, n0, m1, n1;
    logic          swap;

    logic signed [CB+1:0] r_sum, den_ext;

    always_comb begin
        span_x = (s_data.start_x > s_data.end_x) ? s_data.start_x - s_data.end_x
                                                 : s_data.end_x - s_data.start_x;
        span_y = (s_data.start_y > s_data.end_y) ? s_data.start_y - s_data.end_y
                                                 : s_data.end_y - s_data.start_y;
        steep  = span_x < span_y;
        m0     = steep ? s_data.start_y : s_data.start_x;
        n0     = steep ? s_data.start_x : s_data.start_y;
        m1     = steep ? s_data.end_y   : s_data.end_x;
        n1     = steep ? s_data.end_x   : s_data.end_y;
        swap   = m0 > m1;
    end

    // advance the quotient: value is q + r/den with 0 <= r < den
    always_comb begin
        den_ext = signed'({2'b00, den_reg});
        r_sum   = r_reg + (CB+2)'(dn_reg);
        q_next  = q_reg;
        r_next  = r_sum;
        if (!dn_reg[CB]) begin
            if (r_sum >= den_ext) begin
                r_next = r_sum - den_ext;
                q_next = q_reg + CB'(1);
            end
        end else if (r_sum[CB+1]) begin
            r_next = r_sum + den_ext;
            q_next = q_reg - CB'(1);
        end
    end

    assign dp_stat.last = (major_now_reg >= major_last_reg);
    assign m_data       = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= lpr_pkg::COLOR_RESET;
        end else if (cfg_wr_en) begin
            color_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            steep_reg       <= steep;
            major_first_reg <= swap ? m1 : m0;
            minor_first_reg <= swap ? n1 : n0;
            major_last_reg  <= swap ? m0 : m1;
            minor_last_reg  <= swap ? n0 : n1;
            major_now_reg   <= swap ? m1 : m0;
        end else if (dp_cmd.step) begin
            major_now_reg   <= major_now_reg + CB'(1);
        end

        if (dp_cmd.setup) begin
            den_reg <= major_last_reg - major_first_reg;
            dn_reg  <= signed'({1'b0, minor_last_reg}) - signed'({1'b0, minor_first_reg});
            q_reg   <= minor_first_reg;
            r_reg   <= '0;
        end else if (dp_cmd.step) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
        end

        if (dp_cmd.step) begin
            // swap axes back for steep lines
            out_reg.pixel_x     <= steep_reg ? q_reg : major_now_reg;
            out_reg.pixel_y     <= steep_reg ? major_now_reg : q_reg;
            out_reg.pixel_color <= color_reg;
            out_reg.last_pixel  <= dp_stat.last;
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_line_pixel_rasterizer.sv
// Self-checking testbench for the line pixel rasterizer.
`timescale 1ns / 1ps

module tb_line_pixel_rasterizer;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    lpr_pkg::in_item_t              s_data      = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    lpr_pkg::out_item_t             m_data;
    logic                           cfg_wr_en   = 1'b0;
    logic [lpr_pkg::COLOR_BITS-1:0] cfg_wr_data = '0;

    always #1 aclk = ~aclk;

    line_pixel_rasterizer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Line state tracked alongside the block
    logic [lpr_pkg::COLOR_BITS-1:0] color_now = lpr_pkg::COLOR_RESET;
    logic [lpr_pkg::COORD_BITS-1:0] run_pos   = '0;
    logic [lpr_pkg::COORD_BITS-1:0] run_lo    = '0;
    logic [lpr_pkg::COORD_BITS-1:0] run_hi    = '0;
    logic [lpr_pkg::COORD_BITS-1:0] side_lo   = '0;
    logic [lpr_pkg::COORD_BITS-1:0] side_hi   = '0;
    logic                           swap_xy   = 1'b0;
    logic                           drawing   = 1'b0;

    lpr_pkg::out_item_t pending_pixels[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int pixels_seen   = 0;
    int lines_started = 0;
    int items_sent    = 0;
    int active_items  = 0;
    int colors_used   = 0;

    function automatic void rasterize_item(input lpr_pkg::in_item_t it);
        int unsigned dx, dy, num, minor;
        logic [lpr_pkg::COORD_BITS-1:0] m0, n0, m1, n1;
        lpr_pkg::out_item_t px;
        if (it.action == lpr_pkg::ACT_START) begin
            dx = 32'((it.start_x > it.end_x) ? it.start_x - it.end_x
                                             : it.end_x - it.start_x);
            dy = 32'((it.start_y > it.end_y) ? it.start_y - it.end_y
                                             : it.end_y - it.start_y);
            swap_xy = (dx < dy);
            if (swap_xy) begin
                m0 = it.start_y; n0 = it.start_x; m1 = it.end_y; n1 = it.end_x;
            end else begin
                m0 = it.start_x; n0 = it.start_y; m1 = it.end_x; n1 = it.end_y;
            end
            if (m0 > m1) begin
                run_lo = m1; side_lo = n1; run_hi = m0; side_hi = n0;
            end else begin
                run_lo = m0; side_lo = n0; run_hi = m1; side_hi = n1;
            end
            run_pos = run_lo;
            drawing = 1'b1;
            lines_started++;
            active_items++;
        end else if (drawing) begin
            if (run_hi <= run_lo) begin
                minor = 32'(side_lo);
            end else begin
                num = int'(side_lo) * (int'(run_hi) - int'(run_pos))
                    + int'(side_hi) * (int'(run_pos) - int'(run_lo));
                minor = num / (int'(run_hi) - int'(run_lo));
            end
            px.pixel_x     = swap_xy ? minor[lpr_pkg::COORD_BITS-1:0] : run_pos;
            px.pixel_y     = swap_xy ? run_pos : minor[lpr_pkg::COORD_BITS-1:0];
            px.pixel_color = color_now;
            px.last_pixel  = (run_pos >= run_hi);
            if (px.last_pixel) drawing = 1'b0;
            else run_pos = run_pos + lpr_pkg::COORD_BITS'(1);
            pending_pixels.push_back(px);
            active_items++;
        end
    endfunction

    function automatic logic [lpr_pkg::COORD_BITS-1:0] near_coord(
            input logic [lpr_pkg::COORD_BITS-1:0] c, input int reach);
        int v;
        v = int'(c) + int'($urandom_range(2 * reach)) - reach;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[lpr_pkg::COORD_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 30)
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_pixel(input lpr_pkg::out_item_t got);
        lpr_pkg::out_item_t want;
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
            report_mismatch("pixel with nothing pending, x", 32'(got.pixel_x), '0);
            return;
        end
        want = pending_pixels.pop_front();
        if (got.pixel_x !== want.pixel_x)
            report_mismatch("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
        if (got.pixel_y !== want.pixel_y)
            report_mismatch("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
        if (got.pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
        if (got.last_pixel !== want.last_pixel)
            report_mismatch("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
    endtask

    // Pixel receiver: check each taken item, then choose the next ready
    always @(posedge aclk) begin
        if (m_valid && m_ready) check_pixel(m_data);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input lpr_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        rasterize_item(it);
        items_sent++;
        // Keep valid up when the next item follows at once
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_start(input logic [lpr_pkg::COORD_BITS-1:0] x0, y0, x1, y1);
        send_item({lpr_pkg::ACT_START, x0, y0, x1, y1});
    endtask

    task automatic send_next();
        send_item({lpr_pkg::ACT_NEXT, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom)});
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_pixels.size() != 0);
    endtask

    task automatic write_color(input logic [lpr_pkg::COLOR_BITS-1:0] c);
        wait_drain();
        // Let a start item finish its setup
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        color_now = c;
        colors_used++;
    endtask

    task automatic test_idle_and_reset_color();
        send_next();
        send_start(8'd0, 8'd0, 8'd0, 8'd0);
        send_next();
        send_next();
    endtask

    task automatic test_directed_lines();
        write_color(32'h0000_0000);
        send_start(8'd255, 8'd255, 8'd255, 8'd255);
        send_next();
        // Equal spans, reversed: abandon after three pixels
        send_start(8'd255, 8'd0, 8'd0, 8'd255);
        repeat (3) send_next();
        write_color(32'hA5C3_3C5A);
        // Steep and reversed
        send_start(8'd3, 8'd255, 8'd1, 8'd250);
        repeat (6) send_next();
        send_start(8'd254, 8'd0, 8'd255, 8'd1);
        repeat (2) send_next();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int budget,
                                       input logic [lpr_pkg::COLOR_BITS-1:0] color);
        int first, r;
        logic [lpr_pkg::COORD_BITS-1:0] x0, y0;
        write_color(color);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        first         = active_items;
        while (active_items - first < budget) begin
            r  = $urandom_range(99);
            x0 = 8'($urandom);
            y0 = 8'($urandom);
            if (r < 65) begin
                send_start(x0, y0, near_coord(x0, 12), near_coord(y0, 12));
                while (drawing) send_next();
                if ($urandom_range(3) == 0) send_next();
            end else if (r < 80) begin
                send_start(x0, y0, 8'($urandom), 8'($urandom));
                repeat ($urandom_range(6)) send_next();
            end else if (r < 88) begin
                repeat ($urandom_range(1, 4))
                    send_item({1'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom)});
            end else if (r < 95) begin
                send_start(x0, y0, x0, y0);
                while (drawing) send_next();
            end else if (r < 98) begin
                send_start(x0, y0, near_coord(x0, 60), near_coord(y0, 60));
                while (drawing) send_next();
            end else begin
                send_start(x0, y0, 8'($urandom), 8'($urandom));
                while (drawing) send_next();
            end
        end
    endtask

    task automatic test_backpressure();
        write_color(32'h0F1E_2D3C);
        send_idle_pct = 0;
        stall_pct     = 0;
        // Hold the output long enough for the input to back up
        hold_left = 300;
        send_start(8'd5, 8'd20, 8'd70, 8'd45);
        while (drawing) send_next();
        wait_drain();
        stall_pct = 50;
        send_start(8'd200, 8'd3, 8'd180, 8'd90);
        repeat (40) send_next();
        send_start(8'd10, 8'd100, 8'd40, 8'd99);
        while (drawing) send_next();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_and_reset_color();
        test_directed_lines();
        test_random_traffic(0, 0, 230, 32'($urandom));
        test_random_traffic(76, 0, 230, 32'hFFFF_FFFF);
        test_random_traffic(0, 76, 230, 32'($urandom));
        test_random_traffic(22, 22, 230, 32'($urandom));
        test_backpressure();
        wait_drain();
        repeat (20) @(posedge aclk);
        $display("Drew %0d lines and compared %0d pixels from %0d items over %0d colors,",
                 lines_started, pixels_seen, items_sent, colors_used);
        $display("with sender gaps, receiver stalls, a long output hold and cut-off lines.");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d pixels still pending", pending_pixels.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: line_pixel_rasterizer.f
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_ctrl.sv
hw/rtl/lpr_datapath.sv
hw/rtl/line_pixel_rasterizer.sv
tb/sv/tb_line_pixel_rasterizer.sv
